// ===== rtl/lfu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants of the lfu cache
// entry layout, request modes, controller states and fixed field widths
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int COUNT_W  = 32;
  localparam int STAMP_W  = 48;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0]   CAP_RESET = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // request modes
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  // one stored entry, valid flag kept inside the memory word
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [COUNT_W-1:0] count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/lfu_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_req_if: request channel of the lfu cache
// valid/ready handshake carrying mode, key and store value
// ----------------------------------------------------------------------------
interface lfu_req_if;
  import lfu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic signed [KEY_W-1:0] lookup_key;
  logic signed [VAL_W-1:0] store_value;

  modport source (output valid, mode, lookup_key, store_value, input ready);
  modport sink   (input valid, mode, lookup_key, store_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/lfu_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_rsp_if: result channel of the lfu cache
// valid/ready handshake carrying hit, read value and eviction flag
// ----------------------------------------------------------------------------
interface lfu_rsp_if;
  import lfu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [VAL_W-1:0] read_value;
  logic                    evicted;

  modport source (output valid, hit, read_value, evicted, input ready);
  modport sink   (input valid, hit, read_value, evicted, output ready);
endinterface
`default_nettype wire

// ===== rtl/lfu_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [ADDR_W-1:0]        waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [ADDR_W-1:0]        raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ===== rtl/lfu_cache_scan_evict_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_cache_scan_evict_top: key-value cache with lfu replacement
// scans one entry ram per request, least-frequent then oldest victim
// ----------------------------------------------------------------------------
// usage
//   in_chan  : request transactions (mode get/put, lookup_key, store_value)
//   out_chan : one result transaction per request (hit, read_value, evicted)
//   cfg_we / cfg_wdata : capacity_in_use, write only while the cache is idle;
//     values above ENTRIES act as ENTRIES, zero turns every put into a no-op
// timing
//   a request runs as an accept, a read of each entry through the single entry
//   ram read port, the return of the last read data and a write-back that also
//   loads the result register
//   one request is in flight at a time; the next request is taken as soon
//   as the write-back is done, even while the previous result still waits
// reset
//   rst_n low clears control state; afterwards a clearing pass writes every
//   ram entry invalid, during which in_chan.ready stays low
// stall
//   if out_chan is stalled the write-back waits until the result register
//   is free, so no result is lost or overwritten
// ----------------------------------------------------------------------------
module lfu_cache_scan_evict_top #(
  parameter int ENTRIES = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [lfu_pkg::CFG_W-1:0] cfg_wdata,
  lfu_req_if.sink                        in_chan,
  lfu_rsp_if.source                      out_chan
);
  import lfu_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CAP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // control
  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   capacity_r;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  logic [CNT_W-1:0]   clr_cnt_r;
  logic [CNT_W-1:0]   rd_cnt_r;
  logic               rvalid_r;
  logic [IDX_W-1:0]   ridx_r;

  // latched request
  logic               mode_r;
  logic [KEY_W-1:0]   key_r;
  logic [VAL_W-1:0]   val_r;

  // scan results
  logic               hit_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic [VAL_W-1:0]   hit_value_r;
  logic [COUNT_W-1:0] hit_count_r;
  logic [CNT_W-1:0]   used_r;
  logic               vic_found_r;
  logic [IDX_W-1:0]   vic_idx_r;
  logic [COUNT_W-1:0] vic_count_r;
  logic [STAMP_W-1:0] vic_stamp_r;
  logic               free_found_r;
  logic [IDX_W-1:0]   free_idx_r;

  // result register
  logic               out_valid_r;
  logic               out_hit_r;
  logic [VAL_W-1:0]   out_read_value_r;
  logic               out_evicted_r;

  // ram port
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  entry_t             rd_entry;
  logic [ENTRY_W-1:0] ram_rdata;

  // combinational helpers
  logic               in_fire;
  logic               out_free;
  logic               wr_fire;
  logic               scan_issue;
  logic               scan_done;
  logic               better_vic;
  logic [CAP_W-1:0]   cap_ext;
  logic [CAP_W-1:0]   cap_eff;
  logic               put_active;
  logic               need_evict;
  logic [COUNT_W-1:0] hit_count_inc;
  logic               res_hit;
  logic [VAL_W-1:0]   res_read_value;
  logic               res_evicted;

  lfu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // handshake and scan bookkeeping
  assign in_fire    = in_chan.valid && in_chan.ready;
  assign out_free   = !out_valid_r || out_chan.ready;
  assign wr_fire    = (state_r == ST_WRITE) && out_free;
  assign scan_issue = (state_r == ST_SCAN) && (rd_cnt_r != CNT_W'(ENTRIES));
  assign scan_done  = (state_r == ST_SCAN) && (rd_cnt_r == CNT_W'(ENTRIES)) && rvalid_r;
  assign ram_raddr  = rd_cnt_r[IDX_W-1:0];

  // lowest count first, then oldest stamp; strict compare keeps lowest index on ties
  assign better_vic = !vic_found_r || (rd_entry.count < vic_count_r) ||
                      ((rd_entry.count == vic_count_r) && (rd_entry.stamp < vic_stamp_r));

  // capacity saturated to the ram depth
  assign cap_ext    = CAP_W'(capacity_r);
  assign cap_eff    = (cap_ext > CAP_W'(ENTRIES)) ? CAP_W'(ENTRIES) : cap_ext;
  assign put_active = (mode_r == MODE_PUT) && (cap_eff != '0);
  assign need_evict = (CAP_W'(used_r) >= cap_eff);
  assign hit_count_inc = (hit_count_r == COUNT_MAX) ? hit_count_r : hit_count_r + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == CNT_W'(ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs: ram write, result and stamp update
  always_comb begin
    in_chan.ready  = (state_r == ST_IDLE);
    ram_we         = 1'b0;
    ram_waddr      = clr_cnt_r[IDX_W-1:0];
    ram_wdata      = '0;
    stamp_nxt      = stamp_r;
    res_hit        = hit_r;
    res_read_value = '0;
    res_evicted    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_WRITE: begin
        ram_wdata.valid = 1'b1;
        ram_wdata.key   = key_r;
        ram_wdata.stamp = stamp_r + 1'b1;
        if (mode_r == MODE_GET) begin
          if (hit_r) begin
            // get hit: bump count and stamp, keep value
            ram_we          = wr_fire;
            ram_waddr       = hit_idx_r;
            ram_wdata.value = hit_value_r;
            ram_wdata.count = hit_count_inc;
            stamp_nxt       = stamp_r + 1'b1;
            res_read_value  = hit_value_r;
          end
        end else if (put_active) begin
          stamp_nxt       = stamp_r + 1'b1;
          ram_we          = wr_fire;
          ram_wdata.value = val_r;
          if (hit_r) begin
            ram_waddr       = hit_idx_r;
            ram_wdata.count = hit_count_inc;
          end else begin
            // new key: take the victim when full, else the first free slot
            ram_wdata.count = COUNT_W'(1);
            ram_waddr       = need_evict ? vic_idx_r : free_idx_r;
            res_evicted     = need_evict;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      capacity_r  <= CAP_RESET;
      stamp_r     <= '0;
      clr_cnt_r   <= '0;
      rd_cnt_r    <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rvalid_r <= scan_issue;
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (in_fire) begin
        rd_cnt_r <= '0;
      end else if (scan_issue) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
      if (wr_fire) begin
        stamp_r     <= stamp_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // scan accumulators, cleared per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r        <= 1'b0;
      vic_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      used_r       <= '0;
    end else if (in_fire) begin
      hit_r        <= 1'b0;
      vic_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      used_r       <= '0;
    end else if (rvalid_r) begin
      if (rd_entry.valid) begin
        used_r <= used_r + 1'b1;
        if (rd_entry.key == key_r) begin
          hit_r <= 1'b1;
        end
        if (better_vic) begin
          vic_found_r <= 1'b1;
        end
      end else if (!free_found_r) begin
        free_found_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_chan.mode;
      key_r  <= KEY_W'(unsigned'(in_chan.lookup_key));
      val_r  <= VAL_W'(unsigned'(in_chan.store_value));
    end
    if (scan_issue) begin
      ridx_r <= rd_cnt_r[IDX_W-1:0];
    end
    if (rvalid_r) begin
      if (rd_entry.valid) begin
        if (rd_entry.key == key_r) begin
          hit_idx_r   <= ridx_r;
          hit_value_r <= rd_entry.value;
          hit_count_r <= rd_entry.count;
        end
        if (better_vic) begin
          vic_idx_r   <= ridx_r;
          vic_count_r <= rd_entry.count;
          vic_stamp_r <= rd_entry.stamp;
        end
      end else if (!free_found_r) begin
        free_idx_r <= ridx_r;
      end
    end
    if (wr_fire) begin
      out_hit_r        <= res_hit;
      out_read_value_r <= res_read_value;
      out_evicted_r    <= res_evicted;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.hit        = out_hit_r;
  assign out_chan.read_value = signed'(out_read_value_r);
  assign out_chan.evicted    = out_evicted_r;

  // a new result only comes from the write-back state
  a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_WRITE))
    else $error("result appeared outside write-back");

  // the scan never writes the ram
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !ram_we)
    else $error("ram write during scan");

  // an eviction only happens on a put of an absent key
  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_fire && res_evicted) |-> (!hit_r && mode_r == MODE_PUT && vic_found_r))
    else $error("eviction without a put miss and a victim");

  // the read counter never exceeds the ram depth
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (rd_cnt_r <= CNT_W'(ENTRIES)))
    else $error("scan pointer overran the ram");

  // a fresh entry always has a slot: a free one or a victim
  a_slot_available: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_fire && put_active && !hit_r) |-> (need_evict ? vic_found_r : free_found_r))
    else $error("insert without a target slot");
endmodule
`default_nettype wire
